// ----- rtl/wcd_pkg.sv -----
// Package: shared types, codes and the status-line prefix table for the deframer.
`timescale 1ns / 1ps
package wcd_pkg;

  localparam logic [2:0] PH_HANDSHAKE = 3'd0;
  localparam logic [2:0] PH_HDR0      = 3'd1;
  localparam logic [2:0] PH_HDR1      = 3'd2;
  localparam logic [2:0] PH_EXT_HI    = 3'd3;
  localparam logic [2:0] PH_EXT_LO    = 3'd4;
  localparam logic [2:0] PH_PAYLOAD   = 3'd5;
  localparam logic [2:0] PH_HALTED    = 3'd6;

  localparam logic [2:0] EV_TEXT     = 3'd0;
  localparam logic [2:0] EV_ACCEPT   = 3'd1;
  localparam logic [2:0] EV_REJECT   = 3'd2;
  localparam logic [2:0] EV_CLOSE    = 3'd3;
  localparam logic [2:0] EV_PONG     = 3'd4;
  localparam logic [2:0] EV_TOO_LONG = 3'd5;
  localparam logic [2:0] EV_MASKED   = 3'd6;

  localparam logic       OP_BYTE    = 1'b0;
  localparam logic       OP_RESTART = 1'b1;

  localparam logic [3:0] OPC_TEXT  = 4'h1;
  localparam logic [3:0] OPC_CLOSE = 4'h8;
  localparam logic [3:0] OPC_PING  = 4'h9;

  localparam logic [3:0] PREFIX_LEN = 4'd12;
  localparam logic [6:0] LEN_EXT16  = 7'd126;
  localparam logic [6:0] LEN_EXT64  = 7'd127;
  localparam logic [7:0] CHAR_CR    = 8'h0d;
  localparam logic [7:0] CHAR_LF    = 8'h0a;

  typedef struct packed {
    logic       vld;
    logic [2:0] ev;
    logic [7:0] data;
    logic       last;
  } res_t;

  // "HTTP/1.1 101"
  function automatic logic [7:0] prefix_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h48;
      4'd1:    c = 8'h54;
      4'd2:    c = 8'h54;
      4'd3:    c = 8'h50;
      4'd4:    c = 8'h2f;
      4'd5:    c = 8'h31;
      4'd6:    c = 8'h2e;
      4'd7:    c = 8'h31;
      4'd8:    c = 8'h20;
      4'd9:    c = 8'h31;
      4'd10:   c = 8'h30;
      4'd11:   c = 8'h31;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ----- rtl/websocket_client_deframer_top.sv -----
// Top level: client-side WebSocket deframer, handshake check then frame parsing.
//
// Input channel (in_valid/in_stall): one transaction per received byte
// (operation 0, rx_byte) or a restart request (operation 1).
// Output channel (out_valid/out_stall): at most one result per input
// transaction: event_res, data_byte, last_of_message.
// A result is registered and appears on the output in the cycle after its input
// transaction is accepted. Throughput: one input transaction per cycle while in_stall
// is low, set by the single parser state update and the one-entry result register.
// in_stall rises only while a result is held and out_stall is high; the
// parser then pauses with its state intact, and the held result stays put.
// Reset (rst, synchronous) returns the block to awaiting the HTTP upgrade
// reply and empties the result register. Close, rejection, too long and
// masked events halt the block; later bytes give nothing until a restart.
`timescale 1ns / 1ps
module websocket_client_deframer_top
  import wcd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       operation,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] event_res,
  output logic [7:0] data_byte,
  output logic       last_of_message
);

  logic accept;
  logic hold;
  res_t res;

  assign in_stall = hold;
  assign accept   = in_valid && !hold;

  wcd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .operation (operation),
    .rx_byte   (rx_byte),
    .res       (res)
  );

  wcd_out_reg u_out_reg (
    .clk             (clk),
    .rst             (rst),
    .accept          (accept),
    .res             (res),
    .hold            (hold),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .event_res       (event_res),
    .data_byte       (data_byte),
    .last_of_message (last_of_message)
  );

endmodule

// ----- rtl/wcd_parser.sv -----
// Parser: handshake check and frame header/payload state, one byte per transaction.
`timescale 1ns / 1ps
module wcd_parser
  import wcd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic       operation,
  input  logic [7:0] rx_byte,
  output res_t       res
);

  logic [2:0]  phase, phase_next;
  logic [3:0]  prefix_index, prefix_index_next;
  logic        prefix_matches, prefix_matches_next;
  logic [1:0]  terminator_count, terminator_count_next;
  logic [3:0]  frame_opcode, frame_opcode_next;
  logic        mask_flag, mask_flag_next;
  logic [7:0]  extended_high, extended_high_next;
  logic [15:0] bytes_remaining, bytes_remaining_next;

  logic [1:0]  term_upd;
  logic        hs_done;
  logic [15:0] rem_dec;
  logic [15:0] start_len;
  logic        start_now;
  logic        complete_now;

  always_comb begin
    term_upd = 2'd0;
    hs_done  = 1'b0;
    if (rx_byte == CHAR_CR) begin
      term_upd = (terminator_count == 2'd2) ? 2'd3 : 2'd1;
    end else if (rx_byte == CHAR_LF) begin
      if (terminator_count == 2'd1) begin
        term_upd = 2'd2;
      end else if (terminator_count == 2'd3) begin
        term_upd = terminator_count;
        hs_done  = 1'b1;
      end
    end
  end

  assign rem_dec = bytes_remaining - 16'd1;

  always_comb begin
    phase_next            = phase;
    prefix_index_next     = prefix_index;
    prefix_matches_next   = prefix_matches;
    terminator_count_next = terminator_count;
    frame_opcode_next     = frame_opcode;
    mask_flag_next        = mask_flag;
    extended_high_next    = extended_high;
    bytes_remaining_next  = bytes_remaining;
    res                   = '0;
    start_now             = 1'b0;
    complete_now          = 1'b0;
    start_len             = 16'd0;

    if (operation == OP_RESTART) begin
      phase_next            = PH_HANDSHAKE;
      prefix_index_next     = 4'd0;
      prefix_matches_next   = 1'b1;
      terminator_count_next = 2'd0;
      frame_opcode_next     = 4'd0;
      mask_flag_next        = 1'b0;
      extended_high_next    = 8'd0;
      bytes_remaining_next  = 16'd0;
    end else begin
      case (phase)
        PH_HANDSHAKE: begin
          terminator_count_next = term_upd;
          if (hs_done) begin
            prefix_index_next     = 4'd0;
            prefix_matches_next   = 1'b1;
            terminator_count_next = 2'd0;
            frame_opcode_next     = 4'd0;
            mask_flag_next        = 1'b0;
            extended_high_next    = 8'd0;
            bytes_remaining_next  = 16'd0;
            res.vld               = 1'b1;
            if ((prefix_index == PREFIX_LEN) && prefix_matches) begin
              phase_next = PH_HDR0;
              res.ev     = EV_ACCEPT;
            end else begin
              phase_next = PH_HALTED;
              res.ev     = EV_REJECT;
            end
          end else if (prefix_index < PREFIX_LEN) begin
            if (rx_byte != prefix_char(prefix_index)) prefix_matches_next = 1'b0;
            prefix_index_next = prefix_index + 4'd1;
          end
        end
        PH_HDR0: begin
          frame_opcode_next = rx_byte[3:0];
          phase_next        = PH_HDR1;
        end
        PH_HDR1: begin
          mask_flag_next = rx_byte[7];
          if (rx_byte[6:0] == LEN_EXT64) begin
            phase_next = PH_HALTED;
            res.vld    = 1'b1;
            res.ev     = EV_TOO_LONG;
          end else if (rx_byte[6:0] == LEN_EXT16) begin
            phase_next = PH_EXT_HI;
          end else if (rx_byte[7]) begin
            phase_next = PH_HALTED;
            res.vld    = 1'b1;
            res.ev     = EV_MASKED;
          end else begin
            start_now = 1'b1;
            start_len = {9'd0, rx_byte[6:0]};
          end
        end
        PH_EXT_HI: begin
          extended_high_next = rx_byte;
          phase_next         = PH_EXT_LO;
        end
        PH_EXT_LO: begin
          if (mask_flag) begin
            phase_next = PH_HALTED;
            res.vld    = 1'b1;
            res.ev     = EV_MASKED;
          end else begin
            start_now = 1'b1;
            start_len = {extended_high, rx_byte};
          end
        end
        PH_PAYLOAD: begin
          bytes_remaining_next = rem_dec;
          if (frame_opcode == OPC_TEXT) begin
            res.vld  = 1'b1;
            res.ev   = EV_TEXT;
            res.data = rx_byte;
            res.last = (rem_dec == 16'd0);
            if (rem_dec == 16'd0) phase_next = PH_HDR0;
          end else if (rem_dec == 16'd0) begin
            complete_now = 1'b1;
          end
        end
        default: begin
        end
      endcase

      if (start_now) begin
        bytes_remaining_next = start_len;
        if (start_len == 16'd0) complete_now = 1'b1;
        else phase_next = PH_PAYLOAD;
      end

      if (complete_now) begin
        phase_next = PH_HDR0;
        if (frame_opcode == OPC_CLOSE) begin
          phase_next = PH_HALTED;
          res.vld    = 1'b1;
          res.ev     = EV_CLOSE;
        end else if (frame_opcode == OPC_PING) begin
          res.vld = 1'b1;
          res.ev  = EV_PONG;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_HANDSHAKE;
      prefix_index     <= 4'd0;
      prefix_matches   <= 1'b1;
      terminator_count <= 2'd0;
      frame_opcode     <= 4'd0;
      mask_flag        <= 1'b0;
      extended_high    <= 8'd0;
      bytes_remaining  <= 16'd0;
    end else if (accept) begin
      phase            <= phase_next;
      prefix_index     <= prefix_index_next;
      prefix_matches   <= prefix_matches_next;
      terminator_count <= terminator_count_next;
      frame_opcode     <= frame_opcode_next;
      mask_flag        <= mask_flag_next;
      extended_high    <= extended_high_next;
      bytes_remaining  <= bytes_remaining_next;
    end
  end

endmodule

// ----- rtl/wcd_out_reg.sv -----
// Result register: holds one result transaction until the receiver takes it.
`timescale 1ns / 1ps
module wcd_out_reg
  import wcd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  res_t       res,
  output logic       hold,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] event_res,
  output logic [7:0] data_byte,
  output logic       last_of_message
);

  logic load;

  assign hold = out_valid && out_stall;
  assign load = !hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= accept && res.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (load && accept && res.vld) begin
      event_res       <= res.ev;
      data_byte       <= res.data;
      last_of_message <= res.last;
    end
  end

endmodule

// ----- sim/websocket_client_deframer_top_test.sv -----
// Testbench for the WebSocket client deframer: directed and random byte streams, checked per result.
`timescale 1ns / 1ps
module websocket_client_deframer_top_test;
  import wcd_pkg::*;

  localparam int unsigned ITEM_TARGET = 1950;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam logic [95:0] STATUS_LINE = "HTTP/1.1 101";
  localparam logic [3:0]  OPC_BINARY = 4'h2;

  typedef struct {
    logic       op;
    logic [7:0] b;
    logic       hold;
  } rx_item_t;

  typedef struct {
    logic [2:0]  ev;
    logic [7:0]  data;
    logic        last;
    int unsigned cyc;
  } ws_event_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       operation = OP_BYTE;
  logic [7:0] rx_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [2:0] event_res;
  logic [7:0] data_byte;
  logic       last_of_message;

  rx_item_t    rx_items[$];
  ws_event_t   expected_events[$];
  int unsigned cycle = 0;
  int unsigned accepted = 0;
  int unsigned results_due = 0;
  int unsigned results_seen = 0;
  int unsigned errors = 0;
  int unsigned event_count[8] = '{default: 0};
  logic        steady = 1'b0;

  // predictor state
  logic [2:0]  ph;
  logic [3:0]  hdr_idx;
  logic        hdr_ok;
  logic [1:0]  crlf_cnt;
  logic [3:0]  opcode_q;
  logic        masked_q;
  logic [7:0]  len_hi_q;
  logic [15:0] remaining;

  websocket_client_deframer_top DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .operation(operation),
    .rx_byte(rx_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .event_res(event_res),
    .data_byte(data_byte),
    .last_of_message(last_of_message)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) cycle <= cycle + 1;

  function automatic void clear_parser();
    ph = PH_HANDSHAKE;
    hdr_idx = '0;
    hdr_ok = 1'b1;
    crlf_cnt = '0;
    opcode_q = '0;
    masked_q = 1'b0;
    len_hi_q = '0;
    remaining = '0;
  endfunction

  function automatic logic frame_done(output ws_event_t e);
    e = '{EV_TEXT, 8'h00, 1'b0, 0};
    ph = PH_HDR0;
    if (opcode_q == OPC_CLOSE) begin
      ph = PH_HALTED;
      e.ev = EV_CLOSE;
      return 1'b1;
    end
    if (opcode_q == OPC_PING) begin
      e.ev = EV_PONG;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic payload_start(input logic [15:0] len, output ws_event_t e);
    e = '{EV_TEXT, 8'h00, 1'b0, 0};
    remaining = len;
    if (len == 16'd0) return frame_done(e);
    ph = PH_PAYLOAD;
    return 1'b0;
  endfunction

  // Advances the predicted parser by one transaction; returns 1 when a result is due.
  function automatic logic deframe_step(input logic op, input logic [7:0] b,
                                        output ws_event_t e);
    logic eoh;
    e = '{EV_TEXT, 8'h00, 1'b0, 0};
    eoh = 1'b0;
    if (op == OP_RESTART) begin
      clear_parser();
      return 1'b0;
    end
    case (ph)
      PH_HANDSHAKE: begin
        if (b == CHAR_CR) begin
          crlf_cnt = (crlf_cnt == 2'd2) ? 2'd3 : 2'd1;
        end else if (b == CHAR_LF) begin
          if (crlf_cnt == 2'd1) crlf_cnt = 2'd2;
          else if (crlf_cnt == 2'd3) eoh = 1'b1;
          else crlf_cnt = 2'd0;
        end else begin
          crlf_cnt = 2'd0;
        end
        if (eoh) begin
          e.ev = (hdr_idx == PREFIX_LEN && hdr_ok) ? EV_ACCEPT : EV_REJECT;
          clear_parser();
          ph = (e.ev == EV_ACCEPT) ? PH_HDR0 : PH_HALTED;
          return 1'b1;
        end
        if (hdr_idx < PREFIX_LEN) begin
          if (b != STATUS_LINE[8 * (PREFIX_LEN - 1 - hdr_idx) +: 8]) hdr_ok = 1'b0;
          hdr_idx = hdr_idx + 4'd1;
        end
        return 1'b0;
      end
      PH_HDR0: begin
        opcode_q = b[3:0];
        ph = PH_HDR1;
        return 1'b0;
      end
      PH_HDR1: begin
        masked_q = b[7];
        if (b[6:0] == LEN_EXT64) begin
          ph = PH_HALTED;
          e.ev = EV_TOO_LONG;
          return 1'b1;
        end
        if (b[6:0] == LEN_EXT16) begin
          ph = PH_EXT_HI;
          return 1'b0;
        end
        if (masked_q) begin
          ph = PH_HALTED;
          e.ev = EV_MASKED;
          return 1'b1;
        end
        return payload_start({9'd0, b[6:0]}, e);
      end
      PH_EXT_HI: begin
        len_hi_q = b;
        ph = PH_EXT_LO;
        return 1'b0;
      end
      PH_EXT_LO: begin
        if (masked_q) begin
          ph = PH_HALTED;
          e.ev = EV_MASKED;
          return 1'b1;
        end
        return payload_start({len_hi_q, b}, e);
      end
      PH_PAYLOAD: begin
        remaining = remaining - 16'd1;
        if (opcode_q == OPC_TEXT) begin
          e.data = b;
          e.last = (remaining == 16'd0);
          if (e.last) ph = PH_HDR0;
          return 1'b1;
        end
        if (remaining == 16'd0) return frame_done(e);
        return 1'b0;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic [7:0] printable();
    return 8'($urandom_range(32, 126));
  endfunction

  task automatic push_item(input logic op, input logic [7:0] b, input logic hold);
    rx_items.push_back('{op, b, hold});
  endtask

  task automatic send_byte(input logic [7:0] b);
    push_item(OP_BYTE, b, 1'b0);
  endtask

  task automatic send_restart(input logic hold);
    push_item(OP_RESTART, 8'($urandom_range(255)), hold);
  endtask

  task automatic send_str(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_crlf();
    send_byte(CHAR_CR);
    send_byte(CHAR_LF);
  endtask

  task automatic send_good_header();
    int unsigned lines;
    lines = $urandom_range(2);
    send_str("HTTP/1.1 101");
    repeat ($urandom_range(8)) send_byte(printable());
    send_crlf();
    repeat (lines) begin
      repeat ($urandom_range(1, 12)) send_byte(printable());
      send_crlf();
    end
    send_crlf();
  endtask

  task automatic send_bad_header();
    logic [95:0] line;
    int unsigned pos;
    logic [7:0]  c;
    line = STATUS_LINE;
    case ($urandom_range(2))
      0: repeat ($urandom_range(11)) send_byte(printable());
      1: begin
        pos = $urandom_range(11);
        do c = printable(); while (c == line[8 * (11 - pos) +: 8]);
        line[8 * (11 - pos) +: 8] = c;
        for (int i = 11; i >= 0; i--) send_byte(line[8 * i +: 8]);
      end
      default: begin
        pos = $urandom_range(10);
        for (int i = 0; i < pos; i++) send_byte(line[8 * (11 - i) +: 8]);
      end
    endcase
    send_crlf();
    send_crlf();
  endtask

  task automatic send_head(input logic [3:0] opc, input logic masked,
                           input int unsigned len, input logic ext);
    send_byte({4'($urandom_range(15)), opc});
    if (ext || len > 125) begin
      send_byte({masked, LEN_EXT16});
      send_byte(len[15:8]);
      send_byte(len[7:0]);
    end else begin
      send_byte({masked, 7'(len)});
    end
  endtask

  task automatic send_frame(input logic [3:0] opc, input int unsigned len, input logic ext);
    send_head(opc, 1'b0, len, ext);
    repeat (len) send_byte(8'($urandom_range(255)));
  endtask

  task automatic send_noise(input int unsigned n);
    repeat (n) send_byte(8'($urandom_range(255)));
  endtask

  always @(posedge clk) begin : drive
    ws_event_t e;
    rx_item_t  item;
    if (rst) begin
      in_valid <= 1'b0;
      clear_parser();
    end else begin
      if (in_valid && !in_stall) begin
        if (deframe_step(operation, rx_byte, e)) begin
          e.cyc = cycle;
          expected_events.push_back(e);
          results_due++;
        end
        accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (rx_items.size() != 0 && (!rx_items[0].hold || results_seen == results_due) &&
            (steady || $urandom_range(99) >= 24)) begin
          item = rx_items.pop_front();
          in_valid <= 1'b1;
          operation <= item.op;
          rx_byte <= item.b;
        end else begin
          in_valid <= 1'b0;
        end
      end
      steady <= (accepted >= 700 && accepted < 1100);
    end
  end

  always @(posedge clk) begin : monitor
    ws_event_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_events.size() == 0 || expected_events[0].cyc >= cycle) begin
          errors++;
          $display("%0t: unexpected result: event %0d data %02h last %0b",
                   $time, event_res, data_byte, last_of_message);
        end else begin
          want = expected_events.pop_front();
          event_count[want.ev]++;
          results_seen <= results_seen + 1;
          if (event_res !== want.ev) begin
            errors++;
            $display("%0t: event_res expected %0d, got %0d", $time, want.ev, event_res);
          end
          if (data_byte !== want.data) begin
            errors++;
            $display("%0t: data_byte expected %02h, got %02h", $time, want.data, data_byte);
          end
          if (last_of_message !== want.last) begin
            errors++;
            $display("%0t: last_of_message expected %0b, got %0b",
                     $time, want.last, last_of_message);
          end
        end
      end
      out_stall <= !steady && ($urandom_range(99) < 24);
    end
  end

  initial begin : watchdog
    forever begin
      @(negedge clk);
      if (cycle >= CYCLE_LIMIT) break;
    end
    $display("%0t: timeout with %0d results outstanding", $time, results_due - results_seen);
    $display("websocket_client_deframer_top regression: fail");
    $finish;
  end

  initial begin : stimulus
    int unsigned nframes;
    int unsigned pick;
    int unsigned len;
    logic [3:0]  opc;

    // header of CR LF CR LF alone is too short, then bytes while halted
    send_crlf();
    send_crlf();
    send_byte(8'h00);
    send_byte(8'hff);
    send_restart(1'b0);
    send_str("HTTP/1.1 101");
    send_crlf();
    send_crlf();
    send_head(OPC_TEXT, 1'b0, 1, 1'b0);
    send_byte(8'h00);
    send_head(OPC_TEXT, 1'b0, 2, 1'b0);
    send_byte(8'hff);
    send_byte(8'h80);
    send_head(OPC_TEXT, 1'b0, 0, 1'b0);
    send_head(OPC_PING, 1'b0, 0, 1'b0);
    push_item(OP_BYTE, {4'h8, OPC_PING}, 1'b1);
    send_byte({1'b0, 7'd1});
    send_byte(8'h7f);
    send_frame(OPC_BINARY, 2, 1'b0);
    send_frame(OPC_TEXT, 3, 1'b1);
    send_head(OPC_CLOSE, 1'b0, 0, 1'b0);
    send_byte(8'h55);
    // restart part way through the handshake; CR CR LF CR LF ends it
    send_restart(1'b0);
    send_str("HTTP/");
    send_restart(1'b0);
    send_str("HTTP/1.1 101");
    send_byte(CHAR_CR);
    send_crlf();
    send_crlf();
    send_head(OPC_TEXT, 1'b1, 5, 1'b0);
    send_restart(1'b0);
    send_good_header();
    send_head(OPC_TEXT, 1'b1, 5, 1'b1);
    send_restart(1'b0);
    send_good_header();
    send_byte({4'h8, OPC_BINARY});
    send_byte({1'b1, LEN_EXT64});
    send_restart(1'b0);
    send_good_header();
    send_head(OPC_TEXT, 1'b0, 3, 1'b0);
    send_byte(8'h41);
    send_restart(1'b0);
    send_str("HTTP/1.0 101");
    send_crlf();
    send_crlf();
    send_restart(1'b0);
    send_str("HTTP/1.1 10");
    send_crlf();
    send_crlf();
    send_restart(1'b0);
    send_good_header();
    send_frame(OPC_CLOSE, 2, 1'b0);

    // random sessions, each opened by a restart
    while (rx_items.size() < ITEM_TARGET) begin
      send_restart($urandom_range(24) == 0);
      if ($urandom_range(99) < 8) begin
        send_bad_header();
        send_noise($urandom_range(3));
      end else begin
        send_good_header();
        nframes = $urandom_range(1, 8);
        for (int k = 0; k < nframes; k++) begin
          pick = $urandom_range(99);
          if (pick < 50) begin
            len = ($urandom_range(49) == 0) ? $urandom_range(256, 400) : $urandom_range(20);
            send_frame(OPC_TEXT, len, $urandom_range(9) == 0);
          end else if (pick < 65) begin
            send_frame(OPC_PING, $urandom_range(5), $urandom_range(9) == 0);
          end else if (pick < 77) begin
            do opc = 4'($urandom_range(15));
            while (opc == OPC_TEXT || opc == OPC_CLOSE || opc == OPC_PING);
            send_frame(opc, $urandom_range(10), $urandom_range(9) == 0);
          end else if (pick < 85) begin
            send_frame(OPC_CLOSE, $urandom_range(3), $urandom_range(9) == 0);
            send_noise($urandom_range(3));
            break;
          end else if (pick < 90) begin
            send_head(4'($urandom_range(15)), 1'b1, $urandom_range(5), 1'($urandom_range(1)));
            send_noise($urandom_range(3));
            break;
          end else if (pick < 94) begin
            send_byte(8'($urandom_range(255)));
            send_byte({1'($urandom_range(1)), LEN_EXT64});
            send_noise($urandom_range(3));
            break;
          end else begin
            // frame cut short by the next restart
            len = $urandom_range(5, 20);
            send_head(OPC_TEXT, 1'b0, len, 1'b0);
            send_noise($urandom_range(len - 1));
            break;
          end
        end
      end
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (rx_items.size() != 0 || in_valid || results_seen != results_due) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("Run covered %0d input transactions and %0d checked results over %0d cycles.",
             accepted, results_seen, cycle);
    $display("Text bytes %0d, accepted %0d, rejected %0d, close %0d,",
             event_count[EV_TEXT], event_count[EV_ACCEPT], event_count[EV_REJECT],
             event_count[EV_CLOSE]);
    $display("pong %0d, too long %0d, masked %0d.",
             event_count[EV_PONG], event_count[EV_TOO_LONG], event_count[EV_MASKED]);
    if (errors == 0) begin
      $display("websocket_client_deframer_top regression: pass");
    end else begin
      $display("websocket_client_deframer_top regression: fail");
    end
    $finish;
  end

endmodule
